// ----- rtl/core/csmu_pkg.sv -----
// ----------------------------------------------------------------------------
// csmu_pkg
// Shared types and constants for the capsule support mapping unit: register
// indexes and the word formats handed between the root and divider cells.
// ----------------------------------------------------------------------------
package csmu_pkg;

   localparam int unsigned CSR_INDEX_W = 2;
   localparam int unsigned CSR_DATA_W  = 31;

   localparam logic [CSR_INDEX_W-1:0] CSR_RADIUS_X   = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_RADIUS_Y   = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_RADIUS_Z   = 2'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_CYL_HEIGHT = 2'd3;

   localparam logic [CSR_DATA_W-1:0] CSR_RESET_VALUE = 31'd65536;

   localparam int unsigned LANES    = 3;
   localparam int unsigned ROOT_W   = 31;   // square root result bits
   localparam int unsigned RAD_W    = 62;   // radicand bits
   localparam int unsigned NUM_W    = 61;   // numerator bits
   localparam int unsigned QUOT_W   = 31;   // quotient bits

   typedef struct packed {
      logic [LANES-1:0] neg;
      logic             ypos;
   } flags_type;

   typedef struct packed {
      logic [LANES-1:0][NUM_W-1:0] num;
      flags_type                   flags;
   } side_type;

   typedef struct packed {
      logic              valid;
      logic [RAD_W-1:0]  rad;
      logic [32:0]       rem;
      logic [ROOT_W-1:0] root;
      side_type          side;
   } sqrt_word_type;

   typedef struct packed {
      logic                         valid;
      logic [ROOT_W-1:0]            len;
      logic                         len_zero;
      logic [LANES-1:0][ROOT_W-1:0] rem;
      logic [LANES-1:0][QUOT_W-1:0] word;
      flags_type                    flags;
   } div_word_type;

endpackage

// ----- rtl/core/csmu_sqrt_cell.sv -----
// ----------------------------------------------------------------------------
// csmu_sqrt_cell
// One step of the digit-by-digit integer square root: takes two radicand
// bits and yields one root bit, then hands the word to the next cell.
// ----------------------------------------------------------------------------
module csmu_sqrt_cell (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   en,
   input  csmu_pkg::sqrt_word_type word_in,
   output csmu_pkg::sqrt_word_type word_out
);

   csmu_pkg::sqrt_word_type word_ff;
   csmu_pkg::sqrt_word_type word_in_next;
   logic [34:0] cur;
   logic [34:0] trial;
   logic        ge;

   always_comb begin
      cur   = {word_in.rem, word_in.rad[csmu_pkg::RAD_W-1 -: 2]};
      trial = {2'b00, word_in.root, 2'b01};
      ge    = (cur >= trial);
      word_in_next       = word_in;
      word_in_next.rem   = ge ? 33'(cur - trial) : cur[32:0];
      word_in_next.root  = {word_in.root[csmu_pkg::ROOT_W-2:0], ge};
      word_in_next.rad   = {word_in.rad[csmu_pkg::RAD_W-3:0], 2'b00};
   end

   always_ff @(posedge clock) begin
      if (en) begin
         word_ff <= word_in_next;
      end
      if (reset) begin
         word_ff.valid <= 1'b0;
      end
   end

   assign word_out = word_ff;

endmodule

// ----- rtl/core/csmu_div_cell.sv -----
// ----------------------------------------------------------------------------
// csmu_div_cell
// One restoring division step on all three lanes: each lane brings one
// numerator bit into its remainder and yields one quotient bit.
// ----------------------------------------------------------------------------
module csmu_div_cell (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  en,
   input  csmu_pkg::div_word_type word_in,
   output csmu_pkg::div_word_type word_out
);

   csmu_pkg::div_word_type word_ff;
   csmu_pkg::div_word_type word_in_next;
   logic [csmu_pkg::ROOT_W:0] trial [csmu_pkg::LANES];
   logic [csmu_pkg::LANES-1:0] ge;

   always_comb begin
      word_in_next = word_in;
      for (int i = 0; i < csmu_pkg::LANES; i++) begin
         trial[i] = {word_in.rem[i], word_in.word[i][csmu_pkg::QUOT_W-1]};
         ge[i]    = (trial[i] >= {1'b0, word_in.len});
         word_in_next.rem[i]  = ge[i] ? csmu_pkg::ROOT_W'(trial[i] - {1'b0, word_in.len})
                                      : trial[i][csmu_pkg::ROOT_W-1:0];
         word_in_next.word[i] = {word_in.word[i][csmu_pkg::QUOT_W-2:0], ge[i]};
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         word_ff <= word_in_next;
      end
      if (reset) begin
         word_ff.valid <= 1'b0;
      end
   end

   assign word_out = word_ff;

endmodule

// ----- rtl/core/capsule_support_mapping_unit.sv -----
// Throughput: one word per cycle while no response word is held up under
// stall; seven front stages, 31 square root cells, 31 divider cells and
// the output register all advance together.
// The whole pipeline holds while a response word waits under stall.
// Reset clears all valid bits and sets every configuration register to 1.0 (65536).
// ----------------------------------------------------------------------------
// capsule_support_mapping_unit
// Support point of an ellipsoid-capped capsule for a query direction,
// Q16.16 fixed point, fully pipelined.
// ----------------------------------------------------------------------------
module capsule_support_mapping_unit (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic signed [31:0]                  req_dir_x,
   input  logic signed [31:0]                  req_dir_y,
   input  logic signed [31:0]                  req_dir_z,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic signed [31:0]                  rsp_point_x,
   output logic signed [31:0]                  rsp_point_y,
   output logic signed [31:0]                  rsp_point_z,
   input  logic                                csr_write,
   input  logic [csmu_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  logic [csmu_pkg::CSR_DATA_W-1:0]     csr_wdata
);

   localparam int unsigned L = csmu_pkg::LANES;

   // Configuration
   logic [L-1:0][30:0] radius_ff;
   logic [30:0]        cyl_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         radius_ff <= {L{csmu_pkg::CSR_RESET_VALUE}};
         cyl_ff    <= csmu_pkg::CSR_RESET_VALUE;
      end else if (csr_write) begin
         case (csr_index)
            csmu_pkg::CSR_RADIUS_X:   radius_ff[0] <= csr_wdata;
            csmu_pkg::CSR_RADIUS_Y:   radius_ff[1] <= csr_wdata;
            csmu_pkg::CSR_RADIUS_Z:   radius_ff[2] <= csr_wdata;
            csmu_pkg::CSR_CYL_HEIGHT: cyl_ff       <= csr_wdata;
            default: ;
         endcase
      end
   end

   // Every stage moves together unless a response word is held up.
   logic en;
   logic rsp_valid_ff;
   assign en        = !rsp_valid_ff || !rsp_stall;
   assign req_stall = !en;

   // Stage 1: sign and magnitude
   logic [L-1:0][31:0] dir;
   logic               s1_valid_ff;
   logic [L-1:0][31:0] s1_mag_ff;
   csmu_pkg::flags_type s1_flags_ff;

   assign dir[0] = req_dir_x;
   assign dir[1] = req_dir_y;
   assign dir[2] = req_dir_z;

   always_ff @(posedge clock) begin
      if (en) begin
         s1_valid_ff <= req_valid;
         for (int i = 0; i < L; i++) begin
            s1_flags_ff.neg[i] <= dir[i][31];
            s1_mag_ff[i]       <= dir[i][31] ? (~dir[i] + 32'd1) : dir[i];
         end
         s1_flags_ff.ypos <= !dir[1][31] && (dir[1] != 32'd0);
      end
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end
   end

   // Stage 2: u = radius * |dir|
   logic [L-1:0][62:0] prod_u;
   logic               s2_valid_ff;
   logic [L-1:0][61:0] s2_u_ff;
   csmu_pkg::flags_type s2_flags_ff;

   always_comb begin
      for (int i = 0; i < L; i++) begin
         prod_u[i] = {32'd0, radius_ff[i]} * {31'd0, s1_mag_ff[i]};
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         s2_valid_ff <= s1_valid_ff;
         s2_flags_ff <= s1_flags_ff;
         for (int i = 0; i < L; i++) begin
            s2_u_ff[i] <= prod_u[i][61:0];
         end
      end
      if (reset) begin
         s2_valid_ff <= 1'b0;
      end
   end

   // Stage 3: the OR of the three has the same top bit as their maximum.
   logic               s3_valid_ff;
   logic [L-1:0][61:0] s3_u_ff;
   logic [61:0]        s3_or_ff;
   csmu_pkg::flags_type s3_flags_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         s3_valid_ff <= s2_valid_ff;
         s3_flags_ff <= s2_flags_ff;
         s3_u_ff     <= s2_u_ff;
         s3_or_ff    <= s2_u_ff[0] | s2_u_ff[1] | s2_u_ff[2];
      end
      if (reset) begin
         s3_valid_ff <= 1'b0;
      end
   end

   // Stage 4: normalising shift count
   logic [6:0]         bit_len;
   logic [5:0]         shift_in;
   logic               s4_valid_ff;
   logic [L-1:0][61:0] s4_u_ff;
   logic [5:0]         s4_shift_ff;
   csmu_pkg::flags_type s4_flags_ff;

   always_comb begin
      bit_len = 7'd0;
      for (int b = 0; b < 62; b++) begin
         if (s3_or_ff[b]) begin
            bit_len = 7'(b + 1);
         end
      end
      shift_in = (bit_len > 7'd30) ? 6'(bit_len - 7'd30) : 6'd0;
   end

   always_ff @(posedge clock) begin
      if (en) begin
         s4_valid_ff <= s3_valid_ff;
         s4_flags_ff <= s3_flags_ff;
         s4_u_ff     <= s3_u_ff;
         s4_shift_ff <= shift_in;
      end
      if (reset) begin
         s4_valid_ff <= 1'b0;
      end
   end

   // Stage 5: v = u >> s, below 2^30
   logic [L-1:0][61:0] shifted;
   logic               s5_valid_ff;
   logic [L-1:0][29:0] s5_v_ff;
   csmu_pkg::flags_type s5_flags_ff;

   always_comb begin
      for (int i = 0; i < L; i++) begin
         shifted[i] = s4_u_ff[i] >> s4_shift_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         s5_valid_ff <= s4_valid_ff;
         s5_flags_ff <= s4_flags_ff;
         for (int i = 0; i < L; i++) begin
            s5_v_ff[i] <= shifted[i][29:0];
         end
      end
      if (reset) begin
         s5_valid_ff <= 1'b0;
      end
   end

   // Stage 6: squares and numerators radius * v
   logic               s6_valid_ff;
   logic [L-1:0][59:0] s6_sq_ff;
   logic [L-1:0][60:0] s6_num_ff;
   csmu_pkg::flags_type s6_flags_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         s6_valid_ff <= s5_valid_ff;
         s6_flags_ff <= s5_flags_ff;
         for (int i = 0; i < L; i++) begin
            s6_sq_ff[i]  <= {30'd0, s5_v_ff[i]} * {30'd0, s5_v_ff[i]};
            s6_num_ff[i] <= {30'd0, radius_ff[i]} * {31'd0, s5_v_ff[i]};
         end
      end
      if (reset) begin
         s6_valid_ff <= 1'b0;
      end
   end

   // Stage 7: sum of squares starts the root chain
   csmu_pkg::sqrt_word_type sq_chain [csmu_pkg::ROOT_W+1];
   csmu_pkg::sqrt_word_type sq_head_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         sq_head_ff.valid      <= s6_valid_ff;
         sq_head_ff.rad        <= {2'b00, s6_sq_ff[0]} + {2'b00, s6_sq_ff[1]}
                                  + {2'b00, s6_sq_ff[2]};
         sq_head_ff.rem        <= '0;
         sq_head_ff.root       <= '0;
         sq_head_ff.side.num   <= s6_num_ff;
         sq_head_ff.side.flags <= s6_flags_ff;
      end
      if (reset) begin
         sq_head_ff.valid <= 1'b0;
      end
   end

   assign sq_chain[0] = sq_head_ff;

   for (genvar k = 0; k < csmu_pkg::ROOT_W; k++) begin : g_sqrt
      csmu_sqrt_cell u_cell (
         .clock    (clock),
         .reset    (reset),
         .en       (en),
         .word_in  (sq_chain[k]),
         .word_out (sq_chain[k+1])
      );
   end

   // The quotient never exceeds the radius, so the top numerator bits can
   // seed the remainder and only 31 steps remain.
   csmu_pkg::sqrt_word_type sq_tail;
   csmu_pkg::div_word_type  dv_chain [csmu_pkg::QUOT_W+1];

   assign sq_tail = sq_chain[csmu_pkg::ROOT_W];

   always_comb begin
      dv_chain[0].valid    = sq_tail.valid;
      dv_chain[0].len      = sq_tail.root;
      dv_chain[0].len_zero = (sq_tail.root == '0);
      dv_chain[0].flags    = sq_tail.side.flags;
      for (int i = 0; i < L; i++) begin
         dv_chain[0].rem[i]  = {1'b0, sq_tail.side.num[i][60:31]};
         dv_chain[0].word[i] = sq_tail.side.num[i][30:0];
      end
   end

   for (genvar k = 0; k < csmu_pkg::QUOT_W; k++) begin : g_div
      csmu_div_cell u_cell (
         .clock    (clock),
         .reset    (reset),
         .en       (en),
         .word_in  (dv_chain[k]),
         .word_out (dv_chain[k+1])
      );
   end

   // Output: signs, half-height offset and saturation
   csmu_pkg::div_word_type dv_tail;
   logic [L-1:0][31:0] e_val;
   logic [30:0]        em;
   logic [33:0]        y_wide;
   logic [33:0]        half_wide;
   logic [31:0]        y_sat;
   logic [31:0]        point_x_ff;
   logic [31:0]        point_y_ff;
   logic [31:0]        point_z_ff;

   assign dv_tail = dv_chain[csmu_pkg::QUOT_W];

   always_comb begin
      for (int i = 0; i < L; i++) begin
         em       = dv_tail.len_zero ? 31'd0 : dv_tail.word[i];
         e_val[i] = dv_tail.flags.neg[i] ? (32'd0 - {1'b0, em}) : {1'b0, em};
      end
      half_wide = {4'd0, cyl_ff[30:1]};
      if (dv_tail.flags.ypos && (cyl_ff != 31'd0)) begin
         y_wide = {{2{e_val[1][31]}}, e_val[1]} + half_wide;
      end else begin
         y_wide = {{2{e_val[1][31]}}, e_val[1]} - half_wide;
      end
      if (y_wide[33:31] == 3'b000 || y_wide[33:31] == 3'b111) begin
         y_sat = y_wide[31:0];
      end else if (y_wide[33]) begin
         y_sat = 32'h8000_0000;
      end else begin
         y_sat = 32'h7FFF_FFFF;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         rsp_valid_ff <= dv_tail.valid;
         point_x_ff   <= e_val[0];
         point_y_ff   <= y_sat;
         point_z_ff   <= e_val[2];
      end
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_point_x = point_x_ff;
   assign rsp_point_y = point_y_ff;
   assign rsp_point_z = point_z_ff;

endmodule

// ----- rtl/core/csmu_checker.sv -----
// ----------------------------------------------------------------------------
// csmu_checker
// Port-level checks on the capsule support mapping unit, bound to the top.
// ----------------------------------------------------------------------------
module csmu_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_stall,
   input logic        rsp_valid,
   input logic        rsp_stall,
   input logic [31:0] rsp_point_x,
   input logic [31:0] rsp_point_y,
   input logic [31:0] rsp_point_z
);

   // A held response word keeps its payload.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_point_x)
         && $stable(rsp_point_y) && $stable(rsp_point_z))
      else $error("response word changed while stalled");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid after reset");

   // The pipeline cannot take a request while its output word is held.
   a_stall_back: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |-> req_stall)
      else $error("request taken while output held");

   // The x and z magnitudes never exceed the radius, so never reach -2^31.
   a_x_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_point_x != 32'h8000_0000)
      else $error("point x out of range");

   a_z_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_point_z != 32'h8000_0000)
      else $error("point z out of range");

endmodule

bind capsule_support_mapping_unit csmu_checker u_csmu_checker (
   .clock       (clock),
   .reset       (reset),
   .req_stall   (req_stall),
   .rsp_valid   (rsp_valid),
   .rsp_stall   (rsp_stall),
   .rsp_point_x (rsp_point_x),
   .rsp_point_y (rsp_point_y),
   .rsp_point_z (rsp_point_z)
);
